// ----- design/tfhc_pkg.sv -----
// Shared types and constants for the TCP frame header classifier.
package tfhc_pkg;

	localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;
	localparam logic [7:0]  ETH_LEN         = 8'd14;
	localparam logic [15:0] IP_MIN_END      = 16'd34;
	localparam logic [7:0]  TCP_PROTO       = 8'd6;
	localparam logic [3:0]  MIN_HDR_WORDS   = 4'd5;
	localparam logic [15:0] POS_IHL         = 16'd14;
	localparam logic [15:0] POS_PROTO       = 16'd23;
	localparam logic [15:0] POS_SRC_ADDR    = 16'd26;
	localparam logic [15:0] POS_DST_ADDR    = 16'd30;
	localparam logic [15:0] POS_IP_END      = 16'd34;
	localparam logic [7:0]  TCP_OFFSET_BYTE = 8'd12;
	localparam logic [7:0]  TCP_MIN_BYTES   = 8'd20;
	localparam logic [23:0] ASCII_GET       = 24'h474554;
	localparam logic [31:0] ASCII_HTTP      = 32'h48545450;

	localparam logic [15:0] WEB_PORT_RST      = 16'd80;
	localparam logic [15:0] TERMINAL_PORT_RST = 16'd23;
	localparam logic [15:0] FILE_PORT_RST     = 16'd21;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_WEB_PORT      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TERMINAL_PORT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FILE_PORT     = 2'd2;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT_ETH,
		ST_SHORT_IP,
		ST_SHORT_IP_OPT,
		ST_NOT_TCP,
		ST_SHORT_TCP,
		ST_BAD_HDR_LEN,
		ST_NO_PAYLOAD
	} status_t;

	typedef enum logic [1:0] {
		SVC_NONE,
		SVC_WEB,
		SVC_TERMINAL,
		SVC_FILE
	} service_t;

	typedef struct packed {
		logic [15:0] byte_position;
		logic [3:0]  ip_words;
		logic [7:0]  protocol_number;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] tcp_sport;
		logic [15:0] tcp_dport;
		logic [3:0]  tcp_words;
		logic [31:0] prefix_bytes;
	} frame_t;

	typedef struct packed {
		logic [15:0] web_port;
		logic [15:0] terminal_port;
		logic [15:0] file_port;
	} port_cfg_t;

	typedef struct packed {
		status_t     status;
		service_t    server_service;
		service_t    client_service;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [15:0] payload_start;
		logic [15:0] payload_length;
		logic        request_prefix;
		logic        response_prefix;
	} result_t;

endpackage

// ----- design/tfhc_capture.sv -----
// Per-frame header capture: byte counter and captured header fields.
module tfhc_capture (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     data_byte,
	input  logic           last_byte,
	output tfhc_pkg::frame_t frame_next
);

	tfhc_pkg::frame_t frame_q;

	logic [7:0]  tcp_start;
	logic [7:0]  pay_start;
	logic [15:0] pos;
	logic [15:0] tcp_lo;
	logic [15:0] pay_lo;
	logic [15:0] pay_k;

	always_comb begin
		pos       = frame_q.byte_position;
		tcp_start = tfhc_pkg::ETH_LEN + {2'b00, frame_q.ip_words, 2'b00};
		pay_start = tcp_start + {2'b00, frame_q.tcp_words, 2'b00};
		tcp_lo    = {8'd0, tcp_start};
		pay_lo    = {8'd0, pay_start};
		pay_k     = pos - pay_lo;
		frame_next = frame_q;
		if (pos != tfhc_pkg::MAX_FRAME_BYTES) begin
			if (pos == tfhc_pkg::POS_IHL) begin
				frame_next.ip_words = data_byte[3:0];
			end
			if (pos == tfhc_pkg::POS_PROTO) begin
				frame_next.protocol_number = data_byte;
			end
			if (pos >= tfhc_pkg::POS_SRC_ADDR && pos < tfhc_pkg::POS_DST_ADDR) begin
				frame_next.src_addr = {frame_q.src_addr[23:0], data_byte};
			end
			if (pos >= tfhc_pkg::POS_DST_ADDR && pos < tfhc_pkg::POS_IP_END) begin
				frame_next.dst_addr = {frame_q.dst_addr[23:0], data_byte};
			end
			if (frame_next.ip_words >= tfhc_pkg::MIN_HDR_WORDS) begin
				if (pos >= tcp_lo && pos < tcp_lo + 16'd2) begin
					frame_next.tcp_sport = {frame_q.tcp_sport[7:0], data_byte};
				end
				if (pos >= tcp_lo + 16'd2 && pos < tcp_lo + 16'd4) begin
					frame_next.tcp_dport = {frame_q.tcp_dport[7:0], data_byte};
				end
				if (pos == tcp_lo + {8'd0, tfhc_pkg::TCP_OFFSET_BYTE}) begin
					frame_next.tcp_words = data_byte[7:4];
				end
			end
			if (frame_next.tcp_words >= tfhc_pkg::MIN_HDR_WORDS
				&& pos >= pay_lo && pos < pay_lo + 16'd4) begin
				unique case (pay_k[1:0])
					2'd0: frame_next.prefix_bytes[31:24] = frame_q.prefix_bytes[31:24] | data_byte;
					2'd1: frame_next.prefix_bytes[23:16] = frame_q.prefix_bytes[23:16] | data_byte;
					2'd2: frame_next.prefix_bytes[15:8]  = frame_q.prefix_bytes[15:8] | data_byte;
					default: frame_next.prefix_bytes[7:0] = frame_q.prefix_bytes[7:0] | data_byte;
				endcase
			end
			frame_next.byte_position = pos + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				frame_q <= '0;
			end else begin
				frame_q <= frame_next;
			end
		end
	end

endmodule

// ----- design/tfhc_classify.sv -----
// Frame classification: status, service match, payload bounds and prefix flags.
module tfhc_classify (
	input  tfhc_pkg::frame_t    frame,
	input  tfhc_pkg::port_cfg_t ports,
	output tfhc_pkg::result_t   result
);

	logic [7:0]  tcp_start;
	logic [7:0]  pay_start;
	logic [15:0] len;
	logic [15:0] plen;
	tfhc_pkg::status_t status;

	function automatic tfhc_pkg::service_t match_service(
		input logic [15:0] port,
		input tfhc_pkg::port_cfg_t cfg
	);
		tfhc_pkg::service_t svc;
		priority if (port == cfg.web_port) begin
			svc = tfhc_pkg::SVC_WEB;
		end else if (port == cfg.terminal_port) begin
			svc = tfhc_pkg::SVC_TERMINAL;
		end else if (port == cfg.file_port) begin
			svc = tfhc_pkg::SVC_FILE;
		end else begin
			svc = tfhc_pkg::SVC_NONE;
		end
		return svc;
	endfunction

	always_comb begin
		len       = frame.byte_position;
		tcp_start = tfhc_pkg::ETH_LEN + {2'b00, frame.ip_words, 2'b00};
		pay_start = tcp_start + {2'b00, frame.tcp_words, 2'b00};
		plen      = len - {8'd0, pay_start};

		priority if (len < {8'd0, tfhc_pkg::ETH_LEN}) begin
			status = tfhc_pkg::ST_SHORT_ETH;
		end else if (len < tfhc_pkg::IP_MIN_END) begin
			status = tfhc_pkg::ST_SHORT_IP;
		end else if (frame.ip_words < tfhc_pkg::MIN_HDR_WORDS) begin
			status = tfhc_pkg::ST_BAD_HDR_LEN;
		end else if (len < {8'd0, tcp_start}) begin
			status = tfhc_pkg::ST_SHORT_IP_OPT;
		end else if (frame.protocol_number != tfhc_pkg::TCP_PROTO) begin
			status = tfhc_pkg::ST_NOT_TCP;
		end else if (len < {8'd0, tcp_start} + {8'd0, tfhc_pkg::TCP_MIN_BYTES}) begin
			status = tfhc_pkg::ST_SHORT_TCP;
		end else if (frame.tcp_words < tfhc_pkg::MIN_HDR_WORDS || len < {8'd0, pay_start}) begin
			status = tfhc_pkg::ST_BAD_HDR_LEN;
		end else if (len == {8'd0, pay_start}) begin
			status = tfhc_pkg::ST_NO_PAYLOAD;
		end else begin
			status = tfhc_pkg::ST_OK;
		end

		result = '0;
		result.status = status;
		if (status == tfhc_pkg::ST_OK || status == tfhc_pkg::ST_NO_PAYLOAD) begin
			result.source_address      = frame.src_addr;
			result.destination_address = frame.dst_addr;
			result.source_port         = frame.tcp_sport;
			result.destination_port    = frame.tcp_dport;
			result.payload_start       = {8'd0, pay_start};
			result.payload_length      = plen;
		end
		if (status == tfhc_pkg::ST_OK) begin
			result.server_service  = match_service(frame.tcp_sport, ports);
			result.client_service  = match_service(frame.tcp_dport, ports);
			result.request_prefix  = (plen >= 16'd3)
				&& (frame.prefix_bytes[31:8] == tfhc_pkg::ASCII_GET);
			result.response_prefix = (plen >= 16'd4)
				&& (frame.prefix_bytes == tfhc_pkg::ASCII_HTTP);
		end
	end

endmodule

// ----- design/tcp_frame_header_classifier.sv -----
// Top level of the TCP frame header classifier.
// Takes one frame byte per cycle; the byte flagged by last_byte closes the frame and,
// after it passes the frame record and output registers, one classification result appears.
// Bytes pass an input register, the header capture counters, a frame record register
// and an output register, so a new frame may start on the cycle after a last byte and
// the sustained rate is one byte per cycle; only a last byte can wait, and only while
// both frame record and output registers hold results and out_ready is low. Port numbers
// must be written by the user through the cfg port while no frame is in flight; unenforced.
module tcp_frame_header_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_enable,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  frame_status,
	output logic [1:0]  server_service,
	output logic [1:0]  client_service,
	output logic [31:0] source_address,
	output logic [31:0] destination_address,
	output logic [15:0] source_port,
	output logic [15:0] destination_port,
	output logic [15:0] payload_start,
	output logic [15:0] payload_length,
	output logic        request_prefix,
	output logic        response_prefix
);

	tfhc_pkg::port_cfg_t ports_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                valid_s2;
	tfhc_pkg::frame_t    frame_s2;
	tfhc_pkg::frame_t    frame_next;
	tfhc_pkg::result_t   result;
	tfhc_pkg::result_t   result_q;
	logic                out_valid_q;
	logic                adv1;
	logic                adv2;
	logic                free2;

	assign adv2     = valid_s2 && (!out_valid_q || out_ready);
	assign free2    = !valid_s2 || adv2;
	assign adv1     = valid_s1 && (!last_s1 || free2);
	assign in_ready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ports_q.web_port      <= tfhc_pkg::WEB_PORT_RST;
			ports_q.terminal_port <= tfhc_pkg::TERMINAL_PORT_RST;
			ports_q.file_port     <= tfhc_pkg::FILE_PORT_RST;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				tfhc_pkg::CFG_WEB_PORT:      ports_q.web_port      <= cfg_data;
				tfhc_pkg::CFG_TERMINAL_PORT: ports_q.terminal_port <= cfg_data;
				tfhc_pkg::CFG_FILE_PORT:     ports_q.file_port     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	tfhc_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv1),
		.data_byte  (byte_s1),
		.last_byte  (last_s1),
		.frame_next (frame_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free2) begin
			valid_s2 <= adv1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && last_s1) begin
			frame_s2 <= frame_next;
		end
	end

	tfhc_classify u_classify (
		.frame  (frame_s2),
		.ports  (ports_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			result_q <= result;
		end
	end

	assign out_valid           = out_valid_q;
	assign frame_status        = result_q.status;
	assign server_service      = result_q.server_service;
	assign client_service      = result_q.client_service;
	assign source_address      = result_q.source_address;
	assign destination_address = result_q.destination_address;
	assign source_port         = result_q.source_port;
	assign destination_port    = result_q.destination_port;
	assign payload_start       = result_q.payload_start;
	assign payload_length      = result_q.payload_length;
	assign request_prefix      = result_q.request_prefix;
	assign response_prefix     = result_q.response_prefix;

endmodule
